@@ hdl/c2p_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c2p_pkg: shared constants, types and table functions for cartesian_to_polar
// fixed-point formats of the cordic datapath, the square root pipeline and
// the arctangent table worked out at elaboration
// ----------------------------------------------------------------------------
package c2p_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int ITERATIONS  = 16;
  localparam int ANGLE_WIDTH = 16;
  localparam int MAG_WIDTH   = 16;

  localparam int ANG_FRAC    = 23;
  localparam int OUT_FRAC    = 7;
  localparam int VEC_FRAC    = 60 - COORD_WIDTH;
  localparam int RAD_FRAC    = 56;
  localparam int HALF_TURN   = 180;
  localparam int FULL_TURN   = 360;

  // components stay below 2^61 after cordic gain; 63 bits hold that with sign
  localparam int VEC_WIDTH   = 63;
  // angle accumulator spans about -100 to +280 degrees
  localparam int ANG_WIDTH   = 34;

  localparam int SQ_WIDTH    = 2 * COORD_WIDTH;
  localparam int SQRT_STEPS  = COORD_WIDTH;
  // stage 0 of the loop forms the sum of squares, the rest are root digits
  localparam int PIPE_DEPTH  = (ITERATIONS > SQRT_STEPS) ? ITERATIONS : SQRT_STEPS + 1;

  localparam logic [63:0] DEG_PER_RAD_Q25 = 64'd1922527338;
  localparam longint      MAG_MAX         = (64'd1 << MAG_WIDTH) - 1;

  typedef logic signed [VEC_WIDTH-1:0] vec_t;
  typedef logic signed [ANG_WIDTH-1:0] ang_t;
  typedef logic [SQ_WIDTH-1:0]         sq_t;

  localparam ang_t FULL_Z   = ang_t'(FULL_TURN) <<< ANG_FRAC;
  localparam ang_t HALF_Z   = ang_t'(HALF_TURN) <<< ANG_FRAC;
  localparam ang_t HALF_LSB = ang_t'(1) <<< (ANG_FRAC - OUT_FRAC - 1);

  // shift-subtract division, elaboration only
  function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    int b;
    q = '0;
    r = '0;
    for (b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // arctan(2^-i) in units of 2^-23 degree, series truncated term by term
  function automatic ang_t atan_step(input int i);
    logic [63:0] rad;
    logic [63:0] term;
    logic [63:0] prod;
    logic        add;
    ang_t        res;
    int          k;
    rad = '0;
    add = 1'b1;
    if (i == 0) begin
      res = ang_t'(45) <<< ANG_FRAC;
    end else begin
      for (k = 1; k <= RAD_FRAC; k += 2) begin
        if (i * k <= RAD_FRAC) begin
          term = udiv64(64'd1 << (RAD_FRAC - i * k), 64'(k));
          rad  = add ? rad + term : rad - term;
          add  = !add;
        end
      end
      prod = (rad >> 24) * DEG_PER_RAD_Q25;
      res  = ang_t'(prod >> 34);
    end
    return res;
  endfunction

endpackage
`default_nettype wire

@@ hdl/cartesian_to_polar.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cartesian_to_polar: vector length and direction
// cordic vectoring pipeline for the angle, digit-per-stage square root
// pipeline for the length, both running side by side
// ----------------------------------------------------------------------------
// pipeline: a taken start passes the input stage, 17 loop stages, the rounding
//   stage and the output register before done is raised
// throughput: one vector per clock, set by the fully unrolled cordic and
//   square root stages; busy is low except during reset
// reset: synchronous rst clears every valid bit, beats in flight are dropped
// the receiver cannot stall, so done is a one-cycle strobe per beat
module cartesian_to_polar (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [c2p_pkg::COORD_WIDTH-1:0] x_coord,
  input  logic signed [c2p_pkg::COORD_WIDTH-1:0] y_coord,
  output logic                                  done,
  output logic [c2p_pkg::ANGLE_WIDTH-1:0]       angle_deg,
  output logic [c2p_pkg::MAG_WIDTH-1:0]         magnitude
);
  import c2p_pkg::*;

  // input stage combinational terms
  logic                       take;
  logic                       x_neg;
  vec_t                       x_ext;
  vec_t                       y_ext;
  logic signed [SQ_WIDTH-1:0] x_sq;
  logic signed [SQ_WIDTH-1:0] y_sq;

  // pipeline registers, index 0 is the input stage
  logic vld [0:PIPE_DEPTH];
  logic nz  [0:PIPE_DEPTH];
  vec_t cx  [0:PIPE_DEPTH];
  vec_t cy  [0:PIPE_DEPTH];
  ang_t z   [0:PIPE_DEPTH];
  sq_t  rem [1:PIPE_DEPTH];
  sq_t  root[1:PIPE_DEPTH];
  sq_t  xx;
  sq_t  yy;

  // rounding stage
  logic                   fin_vld;
  logic                   fin_nz;
  ang_t                   fin_z;
  logic [COORD_WIDTH:0]   fin_mag;

  // output stage terms
  ang_t ang_sum;
  logic ang_wrap;

  // no backpressure: only reset holds off new beats
  assign busy = rst;
  assign take = start && !busy;

  // pre-rotation by a half turn puts the vector in the right half plane
  always_comb begin
    x_neg = x_coord[COORD_WIDTH-1];
    x_ext = vec_t'(x_coord);
    y_ext = vec_t'(y_coord);
    x_sq  = SQ_WIDTH'(x_coord) * SQ_WIDTH'(x_coord);
    y_sq  = SQ_WIDTH'(y_coord) * SQ_WIDTH'(y_coord);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= take;
    end
    cx[0] <= (x_neg ? -x_ext : x_ext) <<< VEC_FRAC;
    cy[0] <= (x_neg ? -y_ext : y_ext) <<< VEC_FRAC;
    z[0]  <= x_neg ? HALF_Z : '0;
    nz[0] <= (|x_coord) || (|y_coord);
    xx    <= sq_t'(x_sq);
    yy    <= sq_t'(y_sq);
  end

  // cordic micro-rotation in stages 0 to 15, root digit in stages 1 to 16 (stage 0 sums squares)
  for (genvar j = 0; j < PIPE_DEPTH; j++) begin : g_stage

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j+1] <= 1'b0;
      end else begin
        vld[j+1] <= vld[j];
      end
      nz[j+1] <= nz[j];
    end

    if (j < ITERATIONS) begin : g_cordic
      localparam ang_t ATAN = atan_step(j);
      // drive y toward zero, the sign of y picks the rotation direction
      always_ff @(posedge clk) begin
        if (!cy[j][VEC_WIDTH-1]) begin
          cx[j+1] <= cx[j] + (cy[j] >>> j);
          cy[j+1] <= cy[j] - (cx[j] >>> j);
          z[j+1]  <= z[j] + ATAN;
        end else begin
          cx[j+1] <= cx[j] - (cy[j] >>> j);
          cy[j+1] <= cy[j] + (cx[j] >>> j);
          z[j+1]  <= z[j] - ATAN;
        end
      end
    end else begin : g_cordic_pass
      always_ff @(posedge clk) begin
        cx[j+1] <= cx[j];
        cy[j+1] <= cy[j];
        z[j+1]  <= z[j];
      end
    end

    if (j == 0) begin : g_sum
      always_ff @(posedge clk) begin
        rem[j+1]  <= xx + yy;
        root[j+1] <= '0;
      end
    end else if (j <= SQRT_STEPS) begin : g_root
      localparam sq_t BIT = sq_t'(1) << (2 * (SQRT_STEPS - j));
      logic [SQ_WIDTH:0] trial;
      assign trial = {1'b0, root[j]} + {1'b0, BIT};
      always_ff @(posedge clk) begin
        if ({1'b0, rem[j]} >= trial) begin
          rem[j+1]  <= rem[j] - trial[SQ_WIDTH-1:0];
          root[j+1] <= (root[j] >> 1) + BIT;
        end else begin
          rem[j+1]  <= rem[j];
          root[j+1] <= root[j] >> 1;
        end
      end
    end else begin : g_root_pass
      always_ff @(posedge clk) begin
        rem[j+1]  <= rem[j];
        root[j+1] <= root[j];
      end
    end
  end

  // fold negative angles into [0,360), round the root to nearest
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_vld <= 1'b0;
    end else begin
      fin_vld <= vld[PIPE_DEPTH];
    end
    fin_nz  <= nz[PIPE_DEPTH];
    fin_z   <= z[PIPE_DEPTH][ANG_WIDTH-1] ? z[PIPE_DEPTH] + FULL_Z : z[PIPE_DEPTH];
    fin_mag <= root[PIPE_DEPTH][COORD_WIDTH:0]
             + (COORD_WIDTH+1)'(rem[PIPE_DEPTH] > root[PIPE_DEPTH]);
  end

  // round half up to 1/128 degree; a result that rounds to a full turn is 0
  always_comb begin
    ang_sum  = fin_z + HALF_LSB;
    ang_wrap = fin_z >= (FULL_Z - HALF_LSB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin_vld;
    end
    // zero vector has no direction, report 0
    angle_deg <= (!fin_nz || ang_wrap) ? '0
               : ang_sum[ANG_FRAC-OUT_FRAC +: ANGLE_WIDTH];
    magnitude <= (33'(fin_mag) > 33'(MAG_MAX)) ? MAG_WIDTH'(MAG_MAX)
               : MAG_WIDTH'(fin_mag);
  end

endmodule
`default_nettype wire
